>>> design/assert_macros.svh
// assertion helpers shared by the line/plane intersection rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define LPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define LPI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/lpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_pkg
// shared constants, status codes and pipeline control type
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

  localparam int ADDR_BITS = 3;
  localparam logic REG_TOL = 1'b0;

  localparam logic [1:0] ST_CROSS   = 2'd0;
  localparam logic [1:0] ST_INPLANE = 2'd1;
  localparam logic [1:0] ST_NOHIT   = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [1:0] status;
    logic [2:0] neg;
    logic [2:0] ovf;
  } lpi_ctl_t;

endpackage

>>> design/lpi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_front
// dot products, zero tests and numerator products ahead of the divider chain
// ----------------------------------------------------------------------------
module lpi_front import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_i,
  input  logic [TOL_BITS-1:0]            tol_i,
  input  logic [2:0][COORD_BITS-1:0]     p_i,
  input  logic [2:0][COORD_BITS-1:0]     d_i,
  input  logic [2:0][COORD_BITS-1:0]     n_i,
  input  logic [2:0][COORD_BITS-1:0]     q_i,
  output lpi_ctl_t                       ctl_o,
  output logic [2:0][COORD_BITS-1:0]     p_o,
  output logic [2*COORD_BITS+1:0]        den_o,
  output logic [2:0][3*COORD_BITS+2:0]   rem_o
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2*C + 1;
  localparam int NW = 2*C + 3;
  localparam int DW = 2*C + 2;
  localparam int AW = 3*C + 3;
  localparam int K  = C + 1;
  localparam int TW = TOL_BITS + FRAC_BITS;
  localparam int CW = (NW > TW) ? NW : TW;

  // stage 1: n.(p-q) and n.d terms
  logic                        v1_r;
  logic signed [PW-1:0]        prn_r [3];
  logic signed [2*C-1:0]       pdn_r [3];
  logic signed [PW-1:0]        prn_nxt [3];
  logic signed [2*C-1:0]       pdn_nxt [3];
  logic [2:0][C-1:0]           p1_r, d1_r;

  always_comb begin
    logic signed [C:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({p_i[i][C-1], p_i[i]}) - $signed({q_i[i][C-1], q_i[i]});
      prn_nxt[i] = PW'($signed(n_i[i])) * PW'(diff);
      pdn_nxt[i] = (2*C)'($signed(n_i[i])) * (2*C)'($signed(d_i[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req_i;
    end
    prn_r <= prn_nxt;
    pdn_r <= pdn_nxt;
    p1_r  <= p_i;
    d1_r  <= d_i;
  end

  // stage 2: sums
  logic                  v2_r;
  logic signed [NW-1:0]  num2_r;
  logic signed [DW-1:0]  den2_r;
  logic [2:0][C-1:0]     p2_r, d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    num2_r <= NW'(prn_r[0]) + NW'(prn_r[1]) + NW'(prn_r[2]);
    den2_r <= DW'(pdn_r[0]) + DW'(pdn_r[1]) + DW'(pdn_r[2]);
    p2_r   <= p1_r;
    d2_r   <= d1_r;
  end

  // stage 3: magnitudes, zero tests, partial products of d*num
  logic [NW-1:0]          num_mag;
  logic [DW-1:0]          den_mag;
  logic [CW-1:0]          thr;
  logic                   den_zero, num_zero;
  logic [C-1:0]           d_mag [3];
  lpi_ctl_t               ctl3_nxt, ctl3_r;
  logic [2*C-1:0]         plo_nxt [3], plo_r [3];
  logic [2*C+2:0]         phi_nxt [3], phi_r [3];
  logic [DW-1:0]          den3_r;
  logic [2:0][C-1:0]      p3_r;

  always_comb begin
    num_mag  = num2_r[NW-1] ? NW'(-num2_r) : NW'(num2_r);
    den_mag  = den2_r[DW-1] ? DW'(-den2_r) : DW'(den2_r);
    thr      = CW'({tol_i, {FRAC_BITS{1'b0}}});
    den_zero = (den2_r == '0) || (CW'(den_mag) < thr);
    num_zero = (num2_r == '0) || (CW'(num_mag) < thr);
    ctl3_nxt.vld    = v2_r;
    ctl3_nxt.status = den_zero ? (num_zero ? ST_INPLANE : ST_NOHIT) : ST_CROSS;
    ctl3_nxt.ovf    = '0;
    for (int i = 0; i < 3; i++) begin
      d_mag[i] = d2_r[i][C-1] ? (~d2_r[i] + C'(1)) : d2_r[i];
      ctl3_nxt.neg[i] = d2_r[i][C-1] ^ num2_r[NW-1] ^ den2_r[DW-1];
      plo_nxt[i] = (2*C)'(d_mag[i]) * (2*C)'(num_mag[C-1:0]);
      phi_nxt[i] = (2*C+3)'(d_mag[i]) * (2*C+3)'(num_mag[NW-1:C]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.vld <= 1'b0;
    end else begin
      ctl3_r.vld <= ctl3_nxt.vld;
    end
    ctl3_r.status <= ctl3_nxt.status;
    ctl3_r.neg    <= ctl3_nxt.neg;
    ctl3_r.ovf    <= ctl3_nxt.ovf;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    den3_r <= den_mag;
    p3_r   <= p2_r;
  end

  // stage 4: join partial products
  lpi_ctl_t           ctl4_r;
  logic [AW-1:0]      prod4_r [3];
  logic [DW-1:0]      den4_r;
  logic [2:0][C-1:0]  p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.vld <= 1'b0;
    end else begin
      ctl4_r.vld <= ctl3_r.vld;
    end
    ctl4_r.status <= ctl3_r.status;
    ctl4_r.neg    <= ctl3_r.neg;
    ctl4_r.ovf    <= ctl3_r.ovf;
    for (int i = 0; i < 3; i++) begin
      prod4_r[i] <= AW'(plo_r[i]) + (AW'(phi_r[i]) << C);
    end
    den4_r <= den3_r;
    p4_r   <= p3_r;
  end

  // stage 5: flag quotients too large for the quotient width
  lpi_ctl_t       ctl5_r;
  logic [AW-1:0]  den_top;
  logic [2:0]     ovf_nxt;

  always_comb begin
    den_top = AW'(den4_r) << K;
    for (int i = 0; i < 3; i++) begin
      ovf_nxt[i] = (prod4_r[i] >= den_top);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r.vld <= 1'b0;
    end else begin
      ctl5_r.vld <= ctl4_r.vld;
    end
    ctl5_r.status <= ctl4_r.status;
    ctl5_r.neg    <= ctl4_r.neg;
    ctl5_r.ovf    <= ovf_nxt;
    for (int i = 0; i < 3; i++) begin
      rem_o[i] <= prod4_r[i];
    end
    den_o <= den4_r;
    p_o   <= p4_r;
  end

  assign ctl_o = ctl5_r;

endmodule

>>> design/lpi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_cell
// one restoring division step for all three coordinates
// ----------------------------------------------------------------------------
module lpi_cell import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int STEP       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpi_ctl_t                      ctl_i,
  input  logic [2:0][COORD_BITS-1:0]    p_i,
  input  logic [2*COORD_BITS+1:0]       den_i,
  input  logic [2:0][3*COORD_BITS+2:0]  rem_i,
  input  logic [2:0][COORD_BITS:0]      quo_i,
  output lpi_ctl_t                      ctl_o,
  output logic [2:0][COORD_BITS-1:0]    p_o,
  output logic [2*COORD_BITS+1:0]       den_o,
  output logic [2:0][3*COORD_BITS+2:0]  rem_o,
  output logic [2:0][COORD_BITS:0]      quo_o
);

  localparam int AW = 3*COORD_BITS + 3;

  logic [AW-1:0]                 den_sh;
  logic [2:0][AW-1:0]            rem_nxt;
  logic [2:0][COORD_BITS:0]      quo_nxt;

  always_comb begin
    den_sh = AW'(den_i) << STEP;
    for (int i = 0; i < 3; i++) begin
      quo_nxt[i] = quo_i[i];
      if (rem_i[i] >= den_sh) begin
        rem_nxt[i]       = rem_i[i] - den_sh;
        quo_nxt[i][STEP] = 1'b1;
      end else begin
        rem_nxt[i] = rem_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.vld <= 1'b0;
    end else begin
      ctl_o.vld <= ctl_i.vld;
    end
    ctl_o.status <= ctl_i.status;
    ctl_o.neg    <= ctl_i.neg;
    ctl_o.ovf    <= ctl_i.ovf;
    p_o   <= p_i;
    den_o <= den_i;
    rem_o <= rem_nxt;
    quo_o <= quo_nxt;
  end

endmodule

>>> design/line_plane_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_plane_intersection
// intersection of a line (point, direction) with a plane (normal, point)
// ----------------------------------------------------------------------------
// A request is taken on each rising edge with start high and busy low. busy
// never rises: the block is fully pipelined and takes one request per cycle,
// back to back, with no gaps.
// Each request gives exactly one result: out_strobe is high for one cycle with
// out_hit_x/y/z and out_status. Results leave in request order.
// The division t = -num/den is done by a chain of COORD_BITS+1 division
// cells, one quotient bit per cell, behind five stages that form the dot
// products, the zero tests and the products d*num.
// out_status: 0 crosses the plane, 1 line lies in the plane (point p is
// returned), 2 parallel with no hit (zero point). Crossing points saturate.
// The receiver cannot stall; results must be taken as they appear.
// Register 0 (byte address 0): tolerance, 16 bits, in units of the fraction
// lsb. Write it only while no request is in flight.
// Synchronous active-low reset empties the pipeline and sets tolerance to 1.
// ----------------------------------------------------------------------------
module line_plane_intersection import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  in_line_px,
  input  logic [COORD_BITS-1:0]  in_line_py,
  input  logic [COORD_BITS-1:0]  in_line_pz,
  input  logic [COORD_BITS-1:0]  in_line_dx,
  input  logic [COORD_BITS-1:0]  in_line_dy,
  input  logic [COORD_BITS-1:0]  in_line_dz,
  input  logic [COORD_BITS-1:0]  in_norm_x,
  input  logic [COORD_BITS-1:0]  in_norm_y,
  input  logic [COORD_BITS-1:0]  in_norm_z,
  input  logic [COORD_BITS-1:0]  in_plane_qx,
  input  logic [COORD_BITS-1:0]  in_plane_qy,
  input  logic [COORD_BITS-1:0]  in_plane_qz,
  output logic                   out_strobe,
  output logic [COORD_BITS-1:0]  out_hit_x,
  output logic [COORD_BITS-1:0]  out_hit_y,
  output logic [COORD_BITS-1:0]  out_hit_z,
  output logic [1:0]             out_status
);

  `include "assert_macros.svh"

  localparam int C   = COORD_BITS;
  localparam int K   = C + 1;
  localparam int DW  = 2*C + 2;
  localparam int AW  = 3*C + 3;
  localparam int SW  = C + 3;
  localparam int LAT = C + 7;

  // configuration port
  logic [TOL_BITS-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOL)) begin
      tol_r <= pwdata[TOL_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOL) ? 32'(tol_r) : 32'd0;
  assign busy   = 1'b0;

  logic [2:0][C-1:0] p_in, d_in, n_in, q_in;

  assign p_in = {in_line_pz, in_line_py, in_line_px};
  assign d_in = {in_line_dz, in_line_dy, in_line_dx};
  assign n_in = {in_norm_z, in_norm_y, in_norm_x};
  assign q_in = {in_plane_qz, in_plane_qy, in_plane_qx};

  lpi_ctl_t               ch_ctl [K+1];
  logic [2:0][C-1:0]      ch_p   [K+1];
  logic [DW-1:0]          ch_den [K+1];
  logic [2:0][AW-1:0]     ch_rem [K+1];
  logic [2:0][K-1:0]      ch_quo [K+1];

  lpi_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (start && !busy),
    .tol_i (tol_r),
    .p_i   (p_in),
    .d_i   (d_in),
    .n_i   (n_in),
    .q_i   (q_in),
    .ctl_o (ch_ctl[0]),
    .p_o   (ch_p[0]),
    .den_o (ch_den[0]),
    .rem_o (ch_rem[0])
  );

  assign ch_quo[0] = '0;

  // division chain, most significant quotient bit first
  for (genvar j = 0; j < K; j++) begin : g_cell
    lpi_cell #(
      .COORD_BITS (COORD_BITS),
      .STEP       (K-1-j)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ch_ctl[j]),
      .p_i   (ch_p[j]),
      .den_i (ch_den[j]),
      .rem_i (ch_rem[j]),
      .quo_i (ch_quo[j]),
      .ctl_o (ch_ctl[j+1]),
      .p_o   (ch_p[j+1]),
      .den_o (ch_den[j+1]),
      .rem_o (ch_rem[j+1]),
      .quo_o (ch_quo[j+1])
    );
  end

  // p + t*d with saturation
  lpi_ctl_t          fin;
  logic [2:0][C-1:0] hit_nxt;
  logic [C-1:0]      max_v, min_v;

  assign fin   = ch_ctl[K];
  assign max_v = {1'b0, {(C-1){1'b1}}};
  assign min_v = {1'b1, {(C-1){1'b0}}};

  always_comb begin
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      qs  = fin.neg[i] ? -$signed(SW'(ch_quo[K][i])) : $signed(SW'(ch_quo[K][i]));
      sum = SW'($signed(ch_p[K][i])) - qs;
      if (fin.status == ST_INPLANE) begin
        hit_nxt[i] = ch_p[K][i];
      end else if (fin.status == ST_NOHIT) begin
        hit_nxt[i] = '0;
      end else if (fin.ovf[i]) begin
        hit_nxt[i] = fin.neg[i] ? max_v : min_v;
      end else if (!sum[SW-1] && (sum[SW-2:C-1] != '0)) begin
        hit_nxt[i] = max_v;
      end else if (sum[SW-1] && (sum[SW-2:C-1] != '1)) begin
        hit_nxt[i] = min_v;
      end else begin
        hit_nxt[i] = sum[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= fin.vld;
    end
    out_hit_x  <= hit_nxt[0];
    out_hit_y  <= hit_nxt[1];
    out_hit_z  <= hit_nxt[2];
    out_status <= fin.status;
  end

  `LPI_ASSERT(a_latency, start && !busy |-> ##(LAT) out_strobe, "result missing after request")
  `LPI_NEVER(a_status_code, out_strobe && (out_status == 2'd3), "unused status code")
  `LPI_ASSERT(a_nohit_zero, out_strobe && (out_status == ST_NOHIT) |-> (out_hit_x == '0) && (out_hit_y == '0) && (out_hit_z == '0), "no-hit point not zero")

endmodule

>>> tb/line_plane_intersection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_plane_intersection_test
// Drives line/plane queries through the command port under several tolerance
// settings, with random gaps in all but one phase. Each accepted request is run through a local
// wide-integer model of the intersection, and every strobed result is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module line_plane_intersection_test;
  import lpi_pkg::*;

  typedef logic [31:0] coord_t;

  typedef struct packed {
    coord_t px, py, pz, dx, dy, dz, nx, ny, nz, qx, qy, qz;
  } query_t;

  typedef struct packed {
    coord_t     hx, hy, hz;
    logic [1:0] status;
  } hit_t;

  typedef logic signed [199:0] big_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  query_t drv_q = '0;
  logic out_strobe;
  coord_t out_hit_x, out_hit_y, out_hit_z;
  logic [1:0] out_status;

  query_t pending_q[$];
  hit_t   expected_hits[$];
  logic [15:0] tol_now = TOL_RESET;
  int unsigned gap_left = 0;
  bit no_gaps = 1'b0;
  int errors = 0;

  always #6 clk = ~clk;

  line_plane_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_line_px(drv_q.px), .in_line_py(drv_q.py), .in_line_pz(drv_q.pz),
    .in_line_dx(drv_q.dx), .in_line_dy(drv_q.dy), .in_line_dz(drv_q.dz),
    .in_norm_x(drv_q.nx), .in_norm_y(drv_q.ny), .in_norm_z(drv_q.nz),
    .in_plane_qx(drv_q.qx), .in_plane_qy(drv_q.qy), .in_plane_qz(drv_q.qz),
    .out_strobe(out_strobe), .out_hit_x(out_hit_x), .out_hit_y(out_hit_y),
    .out_hit_z(out_hit_z), .out_status(out_status)
  );

  function automatic big_t mag(big_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t clamp32(big_t v);
    big_t hi, lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'h7fff_ffff;
    if (v < lo) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic hit_t predict_hit(query_t q, logic [15:0] tol);
    big_t p[3], d[3], n[3], pq[3];
    big_t num, den, thr;
    bit den_zero, num_zero;
    hit_t r;
    p[0] = $signed(q.px); p[1] = $signed(q.py); p[2] = $signed(q.pz);
    d[0] = $signed(q.dx); d[1] = $signed(q.dy); d[2] = $signed(q.dz);
    n[0] = $signed(q.nx); n[1] = $signed(q.ny); n[2] = $signed(q.nz);
    pq[0] = $signed(q.qx); pq[1] = $signed(q.qy); pq[2] = $signed(q.qz);
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      num = num + n[i] * (p[i] - pq[i]);
      den = den + n[i] * d[i];
    end
    thr = 0;
    thr[31:16] = tol;
    den_zero = (den == 0) || (mag(den) < thr);
    num_zero = (num == 0) || (mag(num) < thr);
    if (den_zero && num_zero) begin
      r = {q.px, q.py, q.pz, ST_INPLANE};
    end else if (den_zero) begin
      r = {32'd0, 32'd0, 32'd0, ST_NOHIT};
    end else begin
      // signed division truncates toward zero
      r.hx = clamp32(p[0] - (d[0] * num) / den);
      r.hy = clamp32(p[1] - (d[1] * num) / den);
      r.hz = clamp32(p[2] - (d[2] * num) / den);
      r.status = ST_CROSS;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_hits.push_back(predict_hit(drv_q, tol_now));
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drv_q <= pending_q.pop_front();
        start <= 1'b1;
        if (!no_gaps) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: gap_left <= $urandom_range(1, 3);
            6:                gap_left <= $urandom_range(10, 40);
            default:          gap_left <= 0;
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_hit_x, out_hit_y, out_hit_z, out_status};
      if (expected_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
                     want.hx, want.hy, want.hz, want.status,
                     got.hx, got.hy, got.hz, got.status);
        end
      end
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 6))
           0: return 32'h0000_0000;
           1: return 32'h0000_0001;
           2: return 32'hffff_ffff;
           3: return 32'h7fff_ffff;
           4: return 32'h8000_0000;
           5: return 32'h0001_0000;
           default: return 32'hffff_0000;
         endcase
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic query_t make_query();
    query_t q;
    q = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), pick_coord()};
    // steer towards parallel and in-plane geometry
    case ($urandom_range(0, 5))
      0: begin
        q.dx = q.ny; q.dy = -q.nx; q.dz = 32'd0;
      end
      1: begin
        q.dx = q.ny; q.dy = -q.nx; q.dz = 32'd0;
        q.px = q.qx + q.nz; q.py = q.qy; q.pz = q.qz - q.nx;
      end
      2: begin
        // small offsets so tolerance decides
        q.dx = $urandom_range(0, 8) - 4; q.dy = $urandom_range(0, 8) - 4;
        q.dz = $urandom_range(0, 8) - 4;
        q.nx = $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic write_tol(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_now = v;
  endtask

  // sampled away from the rising edge so driver and monitor updates have settled
  task automatic drain();
    while (pending_q.size() != 0 || start || expected_hits.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] tol_plan[5];
    query_t q;
    tol_plan = '{16'd0, 16'hffff, 16'd0, 16'd0, 16'd1};
    tol_plan[2] = 16'($urandom_range(2, 16'hfffe));
    tol_plan[3] = 16'($urandom_range(1, 64));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at reset tolerance
    pending_q.push_back('0);
    pending_q.push_back({12{32'h7fff_ffff}});
    pending_q.push_back({12{32'h8000_0000}});
    pending_q.push_back({12{32'hffff_ffff}});
    q = '0; q.nz = 32'h0001_0000; q.dz = 32'h0001_0000; q.pz = 32'h0005_0000;
    pending_q.push_back(q);                        // plain crossing
    q.dz = 32'd0; q.dx = 32'h0001_0000;
    pending_q.push_back(q);                        // parallel, off the plane
    q.pz = 32'd0;
    pending_q.push_back(q);                        // lies in the plane
    q = '0; q.nz = 32'h0000_0001; q.dz = 32'h0000_0001; q.pz = 32'h7fff_0000;
    q.dx = 32'h7fff_ffff; q.dy = 32'h8000_0000;
    pending_q.push_back(q);                        // den under the threshold: reported as no hit
    q = '0; q.nz = 32'h0000_0100; q.dz = 32'h0000_0100; q.pz = 32'h0000_0001;
    pending_q.push_back(q);                        // den exactly at the threshold
    q.dz = 32'h0000_00ff;
    pending_q.push_back(q);                        // den just under the threshold
    q = '0; q.nx = 32'h0001_0000; q.dx = 32'hffff_0000; q.px = 32'h8000_0000;
    q.dy = 32'h8000_0000; q.dz = 32'h7fff_ffff;
    pending_q.push_back(q);
    for (int i = 0; i < 10; i++) pending_q.push_back(make_query());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_tol(tol_plan[ph]);
      no_gaps = (ph == 1);
      for (int i = 0; i < 260; i++) pending_q.push_back(make_query());
      drain();
    end

    repeat (60) @(posedge clk);
    if (expected_hits.size() != 0) errors++;
    if (errors == 0) begin
      $display("line_plane_intersection_test: done, clean");
    end else begin
      $display("line_plane_intersection_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("line_plane_intersection_test: done, errors");
    $finish;
  end

endmodule
